FILE: src/pcsw_pkg.sv
// ============================================================================
// pcsw_pkg
// Shared types, constants and the exp2 root table for the waveshaper.
// ============================================================================
`default_nettype none

package pcsw_pkg;

    // Fraction bits of the internal log2 / exp2 values
    localparam int LOG_FB = 20;

    // 1.0 in Q2.14 / Q18.14
    localparam logic [32:0] UNITY14 = 33'd16384;

    // Control bits that travel with each word down the pipeline
    typedef struct packed {
        logic valid;
        logic last;
        logic neg;
        logic zero;
    } ctl_t;

    // Integer square root, bit by bit
    function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
        logic [63:0] n;
        logic [63:0] res;
        logic [63:0] b;
        n   = n_in;
        res = '0;
        b   = 64'h4000_0000_0000_0000;
        for (int i = 0; i < 32; i++)
        begin
            if (n >= res + b)
            begin
                n   = n - (res + b);
                res = (res >> 1) + b;
            end
            else
            begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // 2^(-2^-j) in Q0.32, built by repeated square roots; elaboration only
    function automatic logic [63:0] exp_root(input int j);
        logic [63:0] r;
        r = 64'h1_0000_0000;
        if (j >= 1)
        begin
            r = isqrt64(64'h8000_0000_0000_0000);
        end
        for (int i = 2; i <= LOG_FB; i++)
        begin
            if (i <= j)
            begin
                r = isqrt64(r << 32);
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: src/pcsw_log2.sv
// ============================================================================
// pcsw_log2
// Magnitude, normalize and a 20-stage squaring pipeline for -log2(|x|).
// ============================================================================
`default_nettype none

module pcsw_log2 #(
    parameter int SB = 24
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 en,
    input  wire pcsw_pkg::ctl_t       in_ctl,
    input  wire logic [SB-1:0]        sample,
    output pcsw_pkg::ctl_t            out_ctl,
    output logic [4:0]                out_ip,
    output logic [pcsw_pkg::LOG_FB-1:0] out_frac
);

    localparam int F  = SB - 1;
    localparam int FB = pcsw_pkg::LOG_FB;

    pcsw_pkg::ctl_t ctl0_next;
    pcsw_pkg::ctl_t ctl0_reg;
    logic [SB-1:0]  mag_next;
    logic [SB-1:0]  mag_reg;
    logic [4:0]     n_next;
    logic [4:0]     n_reg;

    pcsw_pkg::ctl_t ctl_reg  [0:FB];
    logic [31:0]    y_reg    [0:FB];
    logic [4:0]     ip_reg   [0:FB];
    logic [FB-1:0]  frac_reg [0:FB];

    // Stage 0: sign, magnitude, leading one
    always_comb
    begin
        ctl0_next       = in_ctl;
        ctl0_next.neg   = sample[SB-1];
        ctl0_next.zero  = (sample == '0);
        mag_next        = sample[SB-1] ? (~sample + SB'(1)) : sample;
        n_next          = '0;
        for (int i = 0; i < SB; i++)
        begin
            if (mag_next[i])
            begin
                n_next = 5'(i);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl0_reg <= '0;
        end
        else if (en)
        begin
            ctl0_reg <= ctl0_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_reg <= mag_next;
            n_reg   <= n_next;
        end
    end

    // Stage 1: normalize to Q1.31
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg[0] <= '0;
        end
        else if (en)
        begin
            ctl_reg[0] <= ctl0_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            y_reg[0]    <= 32'(mag_reg) << (5'd31 - n_reg);
            ip_reg[0]   <= 5'(F) - n_reg;
            frac_reg[0] <= '0;
        end
    end

    // Squaring stages, one fraction bit each
    for (genvar g = 1; g <= FB; g++)
    begin : g_sq
        logic [63:0] sq;
        logic [32:0] sh;
        logic [31:0] y_next;
        logic [FB-1:0] frac_next;

        always_comb
        begin
            sq = 64'(y_reg[g-1]) * 64'(y_reg[g-1]);
            sh = sq[63:31];
            if (sh[32])
            begin
                y_next    = sh[32:1];
                frac_next = {frac_reg[g-1][FB-2:0], 1'b1};
            end
            else
            begin
                y_next    = sh[31:0];
                frac_next = {frac_reg[g-1][FB-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ctl_reg[g] <= '0;
            end
            else if (en)
            begin
                ctl_reg[g] <= ctl_reg[g-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                y_reg[g]    <= y_next;
                frac_reg[g] <= frac_next;
                ip_reg[g]   <= ip_reg[g-1];
            end
        end
    end

    assign out_ctl  = ctl_reg[FB];
    assign out_ip   = ip_reg[FB];
    assign out_frac = frac_reg[FB];

endmodule

`default_nettype wire

FILE: src/pcsw_exp2.sv
// ============================================================================
// pcsw_exp2
// Scale the log by the exponent, then a 20-stage exp2 and final shift.
// ============================================================================
`default_nettype none

module pcsw_exp2 #(
    parameter int SB = 24
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   en,
    input  wire pcsw_pkg::ctl_t         in_ctl,
    input  wire logic [4:0]             ip,
    input  wire logic [pcsw_pkg::LOG_FB-1:0] frac,
    input  wire logic [14:0]            expo,
    output pcsw_pkg::ctl_t              out_ctl,
    output logic [SB-1:0]               p
);

    localparam int F  = SB - 1;
    localparam int FB = pcsw_pkg::LOG_FB;
    localparam logic [SB-1:0] ONE = {1'b1, {F{1'b0}}};

    pcsw_pkg::ctl_t ctl_reg [0:FB];
    logic [32:0]    v_reg   [0:FB];
    logic [7:0]     ti_reg  [0:FB];
    logic [FB-1:0]  tf_reg  [0:FB];

    logic [24:0] neglog;
    logic [39:0] prod;

    pcsw_pkg::ctl_t ctlo_reg;
    logic [SB-1:0]  p_reg;
    logic [8:0]     sh;
    logic [32:0]    pv;
    logic [SB-1:0]  p_next;

    // Stage 0: t = (-log2|x| * e) >> 12
    always_comb
    begin
        neglog = {ip, {FB{1'b0}}} - 25'(frac);
        prod   = 40'(neglog) * 40'(expo);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg[0] <= '0;
        end
        else if (en)
        begin
            ctl_reg[0] <= in_ctl;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v_reg[0]  <= 33'h1_0000_0000;
            ti_reg[0] <= prod[39:32];
            tf_reg[0] <= prod[31:12];
        end
    end

    // One root multiply per fraction bit, most significant first
    for (genvar g = 1; g <= FB; g++)
    begin : g_ex
        localparam logic [31:0] ROOT = 32'(pcsw_pkg::exp_root(g));
        logic [64:0] vm;

        assign vm = 65'(v_reg[g-1]) * 65'(ROOT);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ctl_reg[g] <= '0;
            end
            else if (en)
            begin
                ctl_reg[g] <= ctl_reg[g-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                v_reg[g]  <= tf_reg[g-1][FB-g] ? vm[64:32] : v_reg[g-1];
                ti_reg[g] <= ti_reg[g-1];
                tf_reg[g] <= tf_reg[g-1];
            end
        end
    end

    // Final stage: integer shift, zero input override
    always_comb
    begin
        sh = 9'(32 - F) + 9'(ti_reg[FB]);
        pv = (sh >= 9'd33) ? '0 : (v_reg[FB] >> sh);
        if (ctl_reg[FB].zero)
        begin
            p_next = (expo == '0) ? ONE : '0;
        end
        else
        begin
            p_next = SB'(pv);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctlo_reg <= '0;
        end
        else if (en)
        begin
            ctlo_reg <= ctl_reg[FB];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= p_next;
        end
    end

    assign out_ctl = ctlo_reg;
    assign p       = p_reg;

endmodule

`default_nettype wire

FILE: src/pcsw_clip.sv
// ============================================================================
// pcsw_clip
// Soft clip (1+k)p/(1+kp) through a pipelined divider, level, sign, saturate.
// ============================================================================
`default_nettype none

module pcsw_clip #(
    parameter int SB = 24
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             en,
    input  wire pcsw_pkg::ctl_t   in_ctl,
    input  wire logic [SB-1:0]    p,
    input  wire logic [31:0]      drive,
    input  wire logic [15:0]      level,
    output pcsw_pkg::ctl_t        out_ctl,
    output logic [SB-1:0]         result
);

    localparam int F = SB - 1;
    localparam logic [SB-1:0] ONE  = {1'b1, {F{1'b0}}};
    localparam logic [SB+1:0] ONEW = {2'b00, ONE};
    localparam logic [SB+1:0] MAXW = {2'b00, ONE - SB'(1)};

    // Stage A: numerator and k*p
    pcsw_pkg::ctl_t ca_reg;
    logic [63:0]    num_a_reg;
    logic [31:0]    kph_reg;
    logic [64:0]    num_full;
    logic [63:0]    kp_full;

    assign num_full = 65'(pcsw_pkg::UNITY14 + 33'(drive)) * 65'(p);
    assign kp_full  = 64'(drive) * 64'(p);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ca_reg <= '0;
        end
        else if (en)
        begin
            ca_reg <= in_ctl;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_a_reg <= num_full[63:0];
            kph_reg   <= kp_full[F +: 32];
        end
    end

    // Stage B: denominator
    pcsw_pkg::ctl_t cb_reg;
    logic [63:0]    num_b_reg;
    logic [32:0]    den_b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cb_reg <= '0;
        end
        else if (en)
        begin
            cb_reg <= ca_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_b_reg <= num_a_reg;
            den_b_reg <= pcsw_pkg::UNITY14 + 33'(kph_reg);
        end
    end

    // Stage C and divider stages: index 0 holds the overflow check
    pcsw_pkg::ctl_t cd_reg  [0:SB];
    logic [63:0]    rem_reg [0:SB];
    logic [32:0]    den_reg [0:SB];
    logic [SB-1:0]  q_reg   [0:SB];
    logic           sat_reg [0:SB];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cd_reg[0] <= '0;
        end
        else if (en)
        begin
            cd_reg[0] <= cb_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= num_b_reg;
            den_reg[0] <= den_b_reg;
            q_reg[0]   <= '0;
            sat_reg[0] <= (65'(num_b_reg) >= (65'(den_b_reg) << (F + 1)));
        end
    end

    // One quotient bit per stage, from bit F down to bit 0
    for (genvar d = 1; d <= SB; d++)
    begin : g_div
        logic [64:0] trial;
        logic        ge;

        assign trial = 65'(den_reg[d-1]) << (SB - d);
        assign ge    = (65'(rem_reg[d-1]) >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                cd_reg[d] <= '0;
            end
            else if (en)
            begin
                cd_reg[d] <= cd_reg[d-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[d] <= ge ? 64'(65'(rem_reg[d-1]) - trial) : rem_reg[d-1];
                q_reg[d]   <= {q_reg[d-1][SB-2:0], ge};
                den_reg[d] <= den_reg[d-1];
                sat_reg[d] <= sat_reg[d-1];
            end
        end
    end

    // Stage E: cap and apply output level
    pcsw_pkg::ctl_t ce_reg;
    logic [SB+1:0]  o_reg;
    logic [SB-1:0]  s_cap;
    logic [SB+15:0] lvl_prod;

    always_comb
    begin
        s_cap    = (sat_reg[SB] || (q_reg[SB] > ONE)) ? ONE : q_reg[SB];
        lvl_prod = (SB + 16)'(s_cap) * (SB + 16)'(level);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ce_reg <= '0;
        end
        else if (en)
        begin
            ce_reg <= cd_reg[SB];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            o_reg <= lvl_prod[SB+15:14];
        end
    end

    // Stage F: saturate and restore sign
    pcsw_pkg::ctl_t cf_reg;
    logic [SB-1:0]  res_reg;
    logic [SB-1:0]  res_next;

    always_comb
    begin
        if (ce_reg.neg)
        begin
            res_next = SB'(0) - ((o_reg > ONEW) ? ONE : o_reg[SB-1:0]);
        end
        else
        begin
            res_next = (o_reg > MAXW) ? MAXW[SB-1:0] : o_reg[SB-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cf_reg <= '0;
        end
        else if (en)
        begin
            cf_reg <= ce_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= res_next;
        end
    end

    assign out_ctl = cf_reg;
    assign result  = res_reg;

endmodule

`default_nettype wire

FILE: src/power_curve_soft_clip_waveshaper.sv
// ============================================================================
// power_curve_soft_clip_waveshaper
// Sign-preserving power curve followed by a rational soft clip and gain.
// ============================================================================
// Use:
//   Samples enter on the s_ stream (s_tdata = sample_in, s_tlast = end of
//   buffer) and leave on the m_ stream with tlast copied from the same word.
//   Registers are written on the cfg channel (index 0 shape_exponent Q3.12,
//   1 drive_multiplier Q18.14, 2 output_level Q2.14; index 3 is ignored).
//   cfg_ready is always high; write registers only while the pipeline is
//   empty.
// Timing:
//   One word per cycle unless the output is held. 22 stages of log2 (sign,
//   normalize, then one squaring multiplier each), 22 of exp2 (scale, one
//   root multiplier each, shift), and the soft clip with a divider of
//   SAMPLE_BITS one-bit stages plus five of multiply, compare, saturate.
// Reset and stall:
//   Reset empties the pipeline and loads the register defaults. When the
//   receiver holds m_tready low with a word waiting, the whole pipeline
//   freezes and s_tready drops; nothing is lost or repeated.
// ============================================================================
`default_nettype none

module power_curve_soft_clip_waveshaper #(
    parameter int SAMPLE_BITS = 24
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // fields from bit 0: sample_in[SAMPLE_BITS-1:0], zero fill
    input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]  s_tdata,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic                              s_tlast,
    // fields from bit 0: sample_out[SAMPLE_BITS-1:0], zero fill
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]       m_tdata,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic                                   m_tlast,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [1:0]                        cfg_index,
    input  wire logic [31:0]                       cfg_data
);

    localparam int TW = ((SAMPLE_BITS + 7) / 8) * 8;

    localparam logic [1:0] CFG_SHAPE = 2'd0;
    localparam logic [1:0] CFG_DRIVE = 2'd1;
    localparam logic [1:0] CFG_LEVEL = 2'd2;

    logic [14:0] shape_exponent_reg;
    logic [31:0] drive_multiplier_reg;
    logic [15:0] output_level_reg;

    logic                   adv;
    pcsw_pkg::ctl_t         in_ctl;
    pcsw_pkg::ctl_t         log_ctl;
    pcsw_pkg::ctl_t         exp_ctl;
    pcsw_pkg::ctl_t         out_ctl;
    logic [4:0]             log_ip;
    logic [pcsw_pkg::LOG_FB-1:0] log_frac;
    logic [SAMPLE_BITS-1:0] pw;
    logic [SAMPLE_BITS-1:0] result;

    // Configuration writes: always ready, unknown index dropped
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shape_exponent_reg   <= 15'd4096;
            drive_multiplier_reg <= '0;
            output_level_reg     <= 16'd16384;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_SHAPE: shape_exponent_reg   <= cfg_data[14:0];
                CFG_DRIVE: drive_multiplier_reg <= cfg_data;
                CFG_LEVEL: output_level_reg     <= cfg_data[15:0];
                default:   ;
            endcase
        end
    end

    // Advance every stage together unless the output word is held
    assign adv      = !out_ctl.valid || m_tready;
    assign s_tready = adv;

    always_comb
    begin
        in_ctl       = '0;
        in_ctl.valid = s_tvalid;
        in_ctl.last  = s_tlast;
    end

    pcsw_log2 #(
        .SB (SAMPLE_BITS)
    ) u_log2 (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_ctl   (in_ctl),
        .sample   (s_tdata[SAMPLE_BITS-1:0]),
        .out_ctl  (log_ctl),
        .out_ip   (log_ip),
        .out_frac (log_frac)
    );

    pcsw_exp2 #(
        .SB (SAMPLE_BITS)
    ) u_exp2 (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (adv),
        .in_ctl  (log_ctl),
        .ip      (log_ip),
        .frac    (log_frac),
        .expo    (shape_exponent_reg),
        .out_ctl (exp_ctl),
        .p       (pw)
    );

    pcsw_clip #(
        .SB (SAMPLE_BITS)
    ) u_clip (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (adv),
        .in_ctl  (exp_ctl),
        .p       (pw),
        .drive   (drive_multiplier_reg),
        .level   (output_level_reg),
        .out_ctl (out_ctl),
        .result  (result)
    );

    assign m_tvalid = out_ctl.valid;
    assign m_tlast  = out_ctl.last;
    assign m_tdata  = TW'(result);

`ifndef SYNTHESIS
    // A non-negative input never comes out with the sign bit set
    a_sign_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !out_ctl.neg) |-> !m_tdata[SAMPLE_BITS-1])
        else $error("positive sample produced negative output");

    // An exponent write lands in the register on the next edge
    a_shape_write: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_valid && cfg_ready && (cfg_index == CFG_SHAPE))
        |=> (shape_exponent_reg == $past(cfg_data[14:0])))
        else $error("shape exponent write lost");

    // A held output word keeps the pipeline frozen and input closed
    a_stall_closed: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("input open during output stall");
`endif

endmodule

`default_nettype wire

FILE: tb/power_curve_soft_clip_waveshaper_tb.sv
// ============================================================================
// power_curve_soft_clip_waveshaper_tb
// Self-checking bench: drives sample words through the waveshaper under
// several register settings with random idling on both streams, predicts
// every output word and compares sample and last flag in order.
// ============================================================================
`timescale 1ns / 100ps
`default_nettype none

module power_curve_soft_clip_waveshaper_tb;

    localparam int SAMPLE_BITS = 24;
    localparam int FB          = SAMPLE_BITS - 1;
    localparam int LATENCY     = 49 + SAMPLE_BITS;

    // Register indexes
    localparam logic [1:0] REG_EXPONENT = 2'd0;
    localparam logic [1:0] REG_DRIVE    = 2'd1;
    localparam logic [1:0] REG_LEVEL    = 2'd2;
    localparam logic [1:0] REG_UNUSED   = 2'd3;

    logic        clk;
    logic        rst_n;
    logic [23:0] s_tdata;
    logic        s_tvalid;
    logic        s_tready;
    logic        s_tlast;
    logic [23:0] m_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;

    power_curve_soft_clip_waveshaper #(.SAMPLE_BITS(SAMPLE_BITS)) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),     // [23:0] sample_in
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tlast   (s_tlast),
        .m_tdata   (m_tdata),     // [23:0] sample_out
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    typedef struct packed {
        logic [23:0] sample;
        logic        last;
    } shaped_t;

    // Shadow copies of the block's registers
    logic [14:0] shadow_exponent;
    logic [31:0] shadow_drive;
    logic [15:0] shadow_level;

    logic [63:0] root_tab [0:20];
    shaped_t     shaped_q [$];
    int          fail_count;
    int          word_count;
    int          setting_count;
    int          rx_wait;

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Plain integer square root used to build the exp2 roots
    function automatic logic [63:0] root64(input logic [63:0] n_in);
        logic [63:0] n;
        logic [63:0] r;
        logic [63:0] b;
        n = n_in;
        r = 0;
        b = 64'd1 << 62;
        while (b > n)
            b = b >> 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // |x|^e in Q1.FB via truncated log2 / exp2
    function automatic logic [63:0] raise_mag(input logic [63:0] mag, input logic [14:0] e);
        int          n;
        logic [63:0] y;
        logic [63:0] frac;
        logic [63:0] neglog;
        logic [63:0] t;
        logic [63:0] tf;
        logic [63:0] ti;
        logic [63:0] v;
        logic [127:0] prod;
        n = 31;
        while (n > 0 && mag[n] == 1'b0)
            n--;
        y = mag << (31 - n);
        frac = 0;
        for (int i = 0; i < 20; i++)
        begin
            y = (y * y) >> 31;
            frac = frac << 1;
            if (y >= (64'd1 << 32))
            begin
                frac = frac | 64'd1;
                y = y >> 1;
            end
        end
        neglog = (64'(FB - n) << 20) - frac;
        t  = (neglog * 64'(e)) >> 12;
        ti = t >> 20;
        tf = t & 64'hF_FFFF;
        v  = 64'd1 << 32;
        for (int i = 1; i <= 20; i++)
        begin
            if (tf[20 - i])
            begin
                prod = 128'(v) * 128'(root_tab[i]);
                v = prod[95:32];
            end
        end
        if (64'(32 - FB) + ti >= 64)
            return 0;
        return v >> (64'(32 - FB) + ti);
    endfunction

    function automatic shaped_t shape_sample(input logic [23:0] x, input logic last);
        logic [63:0] one_q;
        logic [63:0] mag;
        logic [63:0] p;
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] s;
        logic [63:0] o;
        logic        neg;
        shaped_t     r;
        one_q = 64'd1 << FB;
        neg = x[23];
        mag = neg ? (64'd1 << 24) - 64'(x) : 64'(x);
        if (mag == 0)
            p = (shadow_exponent == 0) ? one_q : 0;
        else
            p = raise_mag(mag, shadow_exponent);
        num = (64'd16384 + 64'(shadow_drive)) * p;
        den = 64'd16384 + ((64'(shadow_drive) * p) >> FB);
        s = num / den;
        if (s > one_q)
            s = one_q;
        o = (s * 64'(shadow_level)) >> 14;
        if (neg)
        begin
            if (o > one_q)
                o = one_q;
            r.sample = 24'((64'd1 << 24) - o);
        end
        else
        begin
            if (o > one_q - 1)
                o = one_q - 1;
            r.sample = o[23:0];
        end
        r.last = last;
        return r;
    endfunction

    // Write one register; mirror it in the shadow copy, then idle with valid low
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_EXPONENT: shadow_exponent = value[14:0];
            REG_DRIVE:    shadow_drive    = value;
            REG_LEVEL:    shadow_level    = value[15:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    // Send one word; queue its prediction or a typed-in expectation.
    // Valid stays high after the word so the next one can follow at once.
    task automatic send_sample(input logic [23:0] x, input logic last,
                               input logic use_fixed, input logic [23:0] fixed_out);
        shaped_t expd;
        int gap;
        gap = $urandom_range(0, 8);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap)
                @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= x;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        expd = shape_sample(x, last);
        if (use_fixed)
            expd.sample = fixed_out;
        shaped_q.push_back(expd);
        word_count++;
    endtask

    // Close the input, hold until every expected word has come, then idle
    task automatic drain;
        s_tvalid <= 1'b0;
        while (shaped_q.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 8)
            @(posedge clk);
    endtask

    // Receiver: draw a random wait after each accepted word
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            rx_wait = 0;
        end
        else if (m_tvalid && m_tready)
        begin
            rx_wait = $urandom_range(0, 8);
            m_tready <= (rx_wait == 0);
        end
        else if (!m_tready)
        begin
            if (rx_wait > 1)
                rx_wait--;
            else
            begin
                rx_wait = 0;
                m_tready <= 1'b1;
            end
        end
    end

    // Compare each accepted output word with the oldest expectation
    always @(posedge clk)
    begin
        shaped_t expd;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (shaped_q.size() == 0)
            begin
                $error("unexpected output word sample_out=%h", m_tdata);
                fail_count++;
            end
            else
            begin
                expd = shaped_q.pop_front();
                if (m_tdata !== expd.sample)
                begin
                    $error("sample_out expected %h actual %h", expd.sample, m_tdata);
                    fail_count++;
                end
                if (m_tlast !== expd.last)
                begin
                    $error("last_out expected %b actual %b", expd.last, m_tlast);
                    fail_count++;
                end
            end
        end
    end

    // Directed rows: sample, last, fixed-result flag, fixed result
    typedef struct {
        logic [23:0] x;
        logic        last;
        logic        fixed;
        logic [23:0] result;
    } row_t;

    row_t rows [0:13] = '{
        '{24'h000000, 1'b0, 1'b1, 24'h000000},   // zero stays zero at e = 1
        '{24'h7FFFFF, 1'b1, 1'b0, 24'h0},        // positive full scale
        '{24'h800000, 1'b0, 1'b1, 24'h800000},   // most negative: magnitude 1.0
        '{24'h000001, 1'b0, 1'b0, 24'h0},        // smallest positive
        '{24'hFFFFFF, 1'b1, 1'b0, 24'h0},        // smallest negative
        '{24'h400000, 1'b0, 1'b0, 24'h0},
        '{24'hC00000, 1'b0, 1'b0, 24'h0},
        '{24'h555555, 1'b1, 1'b0, 24'h0},
        '{24'hAAAAAA, 1'b0, 1'b0, 24'h0},
        '{24'h123456, 1'b0, 1'b0, 24'h0},
        '{24'h000100, 1'b0, 1'b0, 24'h0},
        '{24'hFFFF00, 1'b0, 1'b0, 24'h0},
        '{24'h7FFFFE, 1'b1, 1'b0, 24'h0},
        '{24'h800001, 1'b0, 1'b0, 24'h0}
    };

    // Register settings walked by the random part, extremes included
    logic [31:0] set_exp   [0:7] = '{4096, 1024, 16384, 32767, 0, 6144, 2048, 12000};
    logic [31:0] set_drive [0:7] = '{0, 16384, 32'hFFFFFFFF, 1, 200000, 65536, 0, 5000};
    logic [31:0] set_level [0:7] = '{16384, 65535, 0, 8192, 16384, 32768, 40000, 1};

    initial
    begin
        logic [23:0] x;
        fail_count = 0;
        word_count = 0;
        setting_count = 0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        shadow_exponent = 15'd4096;
        shadow_drive = 32'd0;
        shadow_level = 16'd16384;
        root_tab[0] = 64'd1 << 32;
        root_tab[1] = root64(64'd1 << 63);
        for (int j = 2; j <= 20; j++)
            root_tab[j] = root64(root_tab[j - 1] << 32);
        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset defaults first: identity curve with unity gain
        foreach (rows[i])
            send_sample(rows[i].x, rows[i].last, rows[i].fixed, rows[i].result);
        drain();

        // Unused index must leave the registers alone
        write_reg(REG_UNUSED, 32'hFFFFFFFF);
        send_sample(24'h400000, 1'b0, 1'b0, 24'h0);
        drain();

        // Zero exponent: every sample, zero included, gives full scale
        write_reg(REG_EXPONENT, 32'd0);
        send_sample(24'h000000, 1'b0, 1'b1, 24'h7FFFFF);
        send_sample(24'h000001, 1'b0, 1'b1, 24'h7FFFFF);
        send_sample(24'hFFFFFF, 1'b1, 1'b1, 24'h800000);
        drain();

        // Zero output level silences everything
        write_reg(REG_LEVEL, 32'd0);
        send_sample(24'h7FFFFF, 1'b0, 1'b1, 24'h000000);
        send_sample(24'h800000, 1'b1, 1'b1, 24'h000000);
        drain();

        // Random part: 8 settings of 75 words each
        for (int k = 0; k < 8; k++)
        begin
            write_reg(REG_EXPONENT, set_exp[k]);
            write_reg(REG_DRIVE, set_drive[k]);
            write_reg(REG_LEVEL, set_level[k]);
            setting_count++;
            for (int n = 0; n < 75; n++)
            begin
                case ($urandom_range(0, 5))
                    0: x = {$urandom_range(0, 1) ? 4'h7 : 4'h8, 20'($urandom)};
                    1: x = 24'($urandom_range(0, 255)) ^ {24{$urandom_range(0, 1) == 1}};
                    default: x = 24'($urandom);
                endcase
                send_sample(x, $urandom_range(0, 7) == 0, 1'b0, 24'h0);
            end
            drain();
        end

        $display("Sent %0d sample words over %0d random register settings plus directed cases.",
                 word_count, setting_count);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial
    begin
        #20ms;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire

FILE: files.f
src/pcsw_pkg.sv
src/pcsw_log2.sv
src/pcsw_exp2.sv
src/pcsw_clip.sv
src/power_curve_soft_clip_waveshaper.sv
tb/power_curve_soft_clip_waveshaper_tb.sv
